// ----- rtl/core/psfc_pkg.sv -----
// shared constants and types for the particle sensor frame checker
package psfc_pkg;

  localparam logic [7:0]  CRC_INIT = 8'hFF;
  localparam logic [7:0]  CRC_POLY = 8'h31;
  localparam logic [15:0] MARKER   = 16'hFFFF;

  localparam logic [1:0] PHASE_HIGH = 2'd0;
  localparam logic [1:0] PHASE_LOW  = 2'd1;
  localparam logic [1:0] PHASE_CRC  = 2'd2;
  localparam logic [1:0] LAST_WORD  = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_CRC    = 2'd1,
    STATUS_MARKER = 2'd2
  } status_t;

endpackage

// ----- rtl/core/psfc_crc8.sv -----
// one-byte crc-8 update, polynomial 0x31, msb first
module psfc_crc8 (
  input  logic [7:0] acc,
  input  logic [7:0] data,
  output logic [7:0] crc
);

  logic [7:0] c;

  always_comb begin
    c = acc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ psfc_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
  end

  assign crc = c;

endmodule

// ----- rtl/core/particle_sensor_frame_checker_top.sv -----
// top level: frame tracking, crc check and result register
// a beat passes the input register, then the result register (two registers)
// throughput: one byte beat per cycle, set by the unrolled crc step, unless stalled
// a frame of twelve beats yields one result beat; other beats yield none
// reset: synchronous, active high; block is idle until a frame start beat,
// crc state is 0xff, input and result registers are empty
module particle_sensor_frame_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pm1_tenths,
  output logic [15:0] pm25_tenths,
  output logic [15:0] pm4_tenths,
  output logic [15:0] pm10_tenths,
  output logic [1:0]  status,
  output logic [1:0]  failed_word
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;

  // frame state
  logic        idle;
  logic [1:0]  word;
  logic [1:0]  phase;
  logic [7:0]  crc_acc;
  logic [7:0]  high_hold;
  logic [15:0] words [4];
  logic        err_seen;
  logic [1:0]  bad_word;

  logic        idle_eff;
  logic [1:0]  word_eff;
  logic [1:0]  phase_eff;
  logic [7:0]  acc_eff;
  logic        err_eff;
  logic [1:0]  bad_eff;
  logic [7:0]  crc_new;
  logic        mismatch;
  logic        err_next;
  logic [1:0]  bad_next;
  logic        s1_last;
  logic        s1_fire;
  logic        marker_hit;

  psfc_crc8 u_crc (
    .acc  (acc_eff),
    .data (s1_byte),
    .crc  (crc_new)
  );

  always_comb begin
    idle_eff  = s1_start ? 1'b0 : idle;
    word_eff  = s1_start ? 2'd0 : word;
    phase_eff = s1_start ? psfc_pkg::PHASE_HIGH : phase;
    acc_eff   = s1_start ? psfc_pkg::CRC_INIT : crc_acc;
    err_eff   = s1_start ? 1'b0 : err_seen;
    bad_eff   = s1_start ? 2'd0 : bad_word;
    mismatch  = (phase_eff == psfc_pkg::PHASE_CRC) && (acc_eff != s1_byte);
    err_next  = err_eff | mismatch;
    bad_next  = (mismatch && !err_eff) ? word_eff : bad_eff;
    s1_last   = !idle_eff && (word_eff == psfc_pkg::LAST_WORD) &&
                (phase_eff == psfc_pkg::PHASE_CRC);
    marker_hit = (words[0] == psfc_pkg::MARKER) || (words[1] == psfc_pkg::MARKER) ||
                 (words[2] == psfc_pkg::MARKER) || (words[3] == psfc_pkg::MARKER);
  end

  // a beat that completes a frame waits for the result register
  assign s1_fire  = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_byte  <= data_byte;
      s1_start <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle      <= 1'b1;
      word      <= 2'd0;
      phase     <= psfc_pkg::PHASE_HIGH;
      crc_acc   <= psfc_pkg::CRC_INIT;
      high_hold <= 8'h00;
      err_seen  <= 1'b0;
      bad_word  <= 2'd0;
    end else if (s1_fire) begin
      if (!idle_eff) begin
        case (phase_eff)
          psfc_pkg::PHASE_HIGH: begin
            crc_acc   <= crc_new;
            high_hold <= s1_byte;
            phase     <= psfc_pkg::PHASE_LOW;
          end
          psfc_pkg::PHASE_LOW: begin
            crc_acc <= crc_new;
            phase   <= psfc_pkg::PHASE_CRC;
          end
          default: begin
            crc_acc <= psfc_pkg::CRC_INIT;
            phase   <= psfc_pkg::PHASE_HIGH;
          end
        endcase
        err_seen <= err_next;
        bad_word <= bad_next;
        word <= (phase_eff == psfc_pkg::PHASE_CRC) ? word_eff + 2'd1 : word_eff;
        idle <= s1_last;
      end
    end
  end

  // reading words carry no reset
  always_ff @(posedge clk) begin
    if (s1_fire && !idle_eff && (phase_eff == psfc_pkg::PHASE_LOW)) begin
      words[word_eff] <= {high_hold, s1_byte};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      if (err_next) begin
        pm1_tenths  <= psfc_pkg::MARKER;
        pm25_tenths <= psfc_pkg::MARKER;
        pm4_tenths  <= psfc_pkg::MARKER;
        pm10_tenths <= psfc_pkg::MARKER;
        status      <= psfc_pkg::STATUS_CRC;
        failed_word <= bad_next;
      end else begin
        pm1_tenths  <= words[0];
        pm25_tenths <= words[1];
        pm4_tenths  <= words[2];
        pm10_tenths <= words[3];
        status      <= marker_hit ? psfc_pkg::STATUS_MARKER : psfc_pkg::STATUS_OK;
        failed_word <= 2'd0;
      end
    end
  end

  a_idle_after_frame: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_last) |=> idle)
    else $error("not idle after last beat of frame");

  a_stall_needs_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid))
    else $error("input stalled without a waiting result");

  a_crc_forces_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == psfc_pkg::STATUS_CRC)) |->
    ((pm1_tenths == psfc_pkg::MARKER) && (pm25_tenths == psfc_pkg::MARKER) &&
     (pm4_tenths == psfc_pkg::MARKER) && (pm10_tenths == psfc_pkg::MARKER)))
    else $error("crc error result without forced readings");

  a_failed_word_only_on_crc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (failed_word != 2'd0)) |-> (status == psfc_pkg::STATUS_CRC))
    else $error("failed word set without crc error");

endmodule

// ----- test/psfc_check_pkg.sv -----
// frame predictor and result scoreboard for the particle sensor frame checker test
package psfc_check_pkg;

  localparam logic [3:0] FRAME_LEN = 4'd12;

  typedef struct packed {
    logic [3:0][15:0]  pm;
    psfc_pkg::status_t st;
    logic [1:0]        bad;
  } reading_set_t;

  class frame_scoreboard;
    logic [3:0]       byte_pos;
    logic [7:0]       crc_acc;
    logic [7:0]       hi_hold;
    logic [3:0][15:0] words;
    bit               crc_bad;
    logic [1:0]       first_bad;
    reading_set_t     readings_q[$];
    int               fails;

    function new();
      byte_pos  = FRAME_LEN;
      crc_acc   = psfc_pkg::CRC_INIT;
      hi_hold   = '0;
      words     = '0;
      crc_bad   = 1'b0;
      first_bad = '0;
      fails     = 0;
    endfunction

    static function logic [7:0] crc8(logic [7:0] acc, logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      for (int i = 0; i < 8; i++) begin
        c = c[7] ? ((c << 1) ^ psfc_pkg::CRC_POLY) : (c << 1);
      end
      return c;
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      reading_set_t r;
      logic [1:0]   w;
      logic [1:0]   ph;
      bit           marker_seen;
      if (start) begin
        byte_pos  = '0;
        crc_acc   = psfc_pkg::CRC_INIT;
        crc_bad   = 1'b0;
        first_bad = '0;
      end
      if (byte_pos >= FRAME_LEN) return;
      w  = 2'(byte_pos / 3);
      ph = 2'(byte_pos % 3);
      case (ph)
        psfc_pkg::PHASE_HIGH: begin
          crc_acc = crc8(crc_acc, b);
          hi_hold = b;
        end
        psfc_pkg::PHASE_LOW: begin
          crc_acc  = crc8(crc_acc, b);
          words[w] = {hi_hold, b};
        end
        default: begin
          if (crc_acc != b && !crc_bad) begin
            crc_bad   = 1'b1;
            first_bad = w;
          end
          crc_acc = psfc_pkg::CRC_INIT;
        end
      endcase
      byte_pos = byte_pos + 4'd1;
      if (byte_pos != FRAME_LEN) return;
      if (crc_bad) begin
        r.pm  = {4{psfc_pkg::MARKER}};
        r.st  = psfc_pkg::STATUS_CRC;
        r.bad = first_bad;
      end else begin
        marker_seen = 1'b0;
        for (int k = 0; k < 4; k++) begin
          if (words[k] == psfc_pkg::MARKER) marker_seen = 1'b1;
        end
        r.pm  = words;
        r.st  = marker_seen ? psfc_pkg::STATUS_MARKER : psfc_pkg::STATUS_OK;
        r.bad = '0;
      end
      readings_q.push_back(r);
    endfunction

    function void check_result(reading_set_t got);
      reading_set_t exp_r;
      string        pm_name[4] = '{"pm1_tenths", "pm25_tenths", "pm4_tenths", "pm10_tenths"};
      if (readings_q.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
        return;
      end
      exp_r = readings_q.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got.pm[k] !== exp_r.pm[k]) begin
          $error("%s expected %h got %h", pm_name[k], exp_r.pm[k], got.pm[k]);
          fails++;
        end
      end
      if (got.st !== exp_r.st) begin
        $error("status expected %0d got %0d", exp_r.st, got.st);
        fails++;
      end
      if (got.bad !== exp_r.bad) begin
        $error("failed_word expected %0d got %0d", exp_r.bad, got.bad);
        fails++;
      end
    endfunction

    function int pending();
      return readings_q.size();
    endfunction
  endclass

endpackage

// ----- test/particle_sensor_frame_checker_top_test.sv -----
// testbench for the particle sensor frame checker: random byte frames against a predictor
module particle_sensor_frame_checker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 1000;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] pm1_tenths;
  logic [15:0] pm25_tenths;
  logic [15:0] pm4_tenths;
  logic [15:0] pm10_tenths;
  logic [1:0]  status;
  logic [1:0]  failed_word;

  psfc_check_pkg::frame_scoreboard sb = new();
  int              frame_bytes_sent = 0;
  int              burst_left = 0;
  int              cycle_count = 0;
  stall_mode_t     stall_mode = STALL_NONE;
  int              stall_left = 0;

  particle_sensor_frame_checker_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pm1_tenths  (pm1_tenths),
    .pm25_tenths (pm25_tenths),
    .pm4_tenths  (pm4_tenths),
    .pm10_tenths (pm10_tenths),
    .status      (status),
    .failed_word (failed_word)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_byte(data_byte, frame_start);
  end

  always @(posedge clk) begin : result_monitor
    psfc_check_pkg::reading_set_t got;
    if (!rst && out_valid && !out_stall) begin
      got.pm  = {pm10_tenths, pm4_tenths, pm25_tenths, pm1_tenths};
      got.st  = psfc_pkg::status_t'(status);
      got.bad = failed_word;
      sb.check_result(got);
    end
  end

  // receiver stall pattern, switching between quiet, light and heavy stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 100);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_SOME: out_stall <= ($urandom_range(0, 2) == 0);
      default:    out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) idle_sender(gap);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid    <= 1'b1;
    data_byte   <= b;
    frame_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // sends the first n_bytes of a frame; bad_crc flips the crc beat of those words
  task automatic send_frame(input logic [3:0][15:0] w, input logic [3:0] bad_crc,
                            input int n_bytes);
    logic [7:0] b;
    int         wd;
    for (int k = 0; k < n_bytes; k++) begin
      wd = k / 3;
      case (k % 3)
        0: b = w[wd][15:8];
        1: b = w[wd][7:0];
        default: begin
          b = psfc_check_pkg::frame_scoreboard::crc8(
                psfc_check_pkg::frame_scoreboard::crc8(psfc_pkg::CRC_INIT, w[wd][15:8]),
                w[wd][7:0]);
          if (bad_crc[wd]) b = b ^ 8'($urandom_range(1, 255));
        end
      endcase
      send_byte(b, k == 0);
      frame_bytes_sent++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return psfc_pkg::MARKER;
    if (pick == 1) return 16'h0000;
    return 16'($urandom());
  endfunction

  initial begin
    logic [3:0][15:0] w;
    logic [3:0]       bad;
    int               pick;
    int               drained;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // bytes while idle, then a partial frame dropped by a new start
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    w = {16'h1234, 16'hABCD, 16'h0F0F, 16'hF0F0};
    send_frame(w, 4'b0000, 3);
    // extremes and a marker word, then a trailing ignored byte
    w = {16'h8001, 16'h7FFE, 16'hFFFF, 16'h0000};
    send_frame(w, 4'b0000, 12);
    send_byte(8'hFF, 1'b0);
    // crc mismatch in two words, first one named
    w = {16'h0001, 16'h00FF, 16'hFF00, 16'h5555};
    send_frame(w, 4'b1100, 12);

    drained = 0;
    while (frame_bytes_sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      for (int k = 0; k < 4; k++) w[k] = rand_word();
      if (pick < 75) begin
        for (int k = 0; k < 4; k++) bad[k] = ($urandom_range(0, 9) == 0);
        send_frame(w, bad, 12);
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
          send_byte(8'($urandom()), 1'b0);
      end else if (pick < 88) begin
        bad = 4'($urandom());
        send_frame(w, bad, $urandom_range(1, 11));
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom()), $urandom_range(0, 7) == 0);
      end
      if (!drained && frame_bytes_sent >= ITEMS / 2) begin
        drain_results();
        drained = 1;
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
